/* sv/bpsd_pkg.sv */
package bpsd_pkg;

  // Widths of the stream, the literals and the tokens
  localparam int ByteW     = 8;
  localparam int LitW      = 32;
  localparam int TokW      = 32;
  localparam int ValW      = (LitW > TokW) ? LitW : TokW;
  localparam int KindW     = 3;
  localparam int ModeW     = 2;
  localparam int ZeroCntW  = 2;

  // Variable-length number coding
  localparam int GroupBits = 7;
  localparam int ShiftW    = 6;
  localparam int ShiftMax  = (1 << ShiftW) - 1;

  // Line markers, by magnitude
  localparam int MarkAddMag = 48;
  localparam int MarkDelMag = 50;

  // Token kinds
  localparam logic [KindW-1:0] KIND_ADD_ID     = 3'd0;
  localparam logic [KindW-1:0] KIND_DEL_START  = 3'd1;
  localparam logic [KindW-1:0] KIND_ITEM       = 3'd2;
  localparam logic [KindW-1:0] KIND_LINE_END   = 3'd3;
  localparam logic [KindW-1:0] KIND_STREAM_END = 3'd4;

  // One finished number as seen by the line parser
  typedef struct packed {
    logic            done;
    logic            add_mark;
    logic            del_mark;
    logic            is_zero;
    logic [TokW-1:0] value;
  } num_t;

endpackage

/* sv/bpsd_varint.sv */
module bpsd_varint (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [bpsd_pkg::ByteW-1:0]  byte_i,
  output bpsd_pkg::num_t              num_o
);

  logic [bpsd_pkg::LitW-1:0]                     acc_q, acc_d, acc_now;
  logic [bpsd_pkg::ShiftW-1:0]                   shift_q, shift_d, shift_sat;
  logic [bpsd_pkg::ShiftW:0]                     shift_sum;
  logic [bpsd_pkg::LitW+bpsd_pkg::GroupBits-1:0] grp_shl;
  logic [bpsd_pkg::LitW-2:0]                     mag;
  logic [bpsd_pkg::ValW-1:0]                     mag_ext, val_full;
  logic                                          neg, cont;

  // Merge the new 7-bit group into the running number
  always_comb begin
    cont    = byte_i[bpsd_pkg::ByteW-1];
    grp_shl = {{bpsd_pkg::LitW{1'b0}}, byte_i[bpsd_pkg::GroupBits-1:0]} << shift_q;
    acc_now = acc_q;
    if ({1'b0, shift_q} < (bpsd_pkg::ShiftW+1)'(bpsd_pkg::LitW)) begin
      acc_now = acc_q | grp_shl[bpsd_pkg::LitW-1:0];
    end
    shift_sum = {1'b0, shift_q} + (bpsd_pkg::ShiftW+1)'(bpsd_pkg::GroupBits);
    if (shift_sum > (bpsd_pkg::ShiftW+1)'(bpsd_pkg::ShiftMax)) begin
      shift_sat = bpsd_pkg::ShiftW'(bpsd_pkg::ShiftMax);
    end else begin
      shift_sat = shift_sum[bpsd_pkg::ShiftW-1:0];
    end
  end

  // Advance on a continued byte, restart after a final one
  always_comb begin
    acc_d   = acc_q;
    shift_d = shift_q;
    if (step_i) begin
      if (cont) begin
        acc_d   = acc_now;
        shift_d = shift_sat;
      end else begin
        acc_d   = '0;
        shift_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      shift_q <= '0;
    end else begin
      acc_q   <= acc_d;
      shift_q <= shift_d;
    end
  end

  // Map the raw number to its signed value: low bit is the sign
  always_comb begin
    neg      = acc_now[0];
    mag      = acc_now[bpsd_pkg::LitW-1:1];
    mag_ext  = bpsd_pkg::ValW'(mag);
    val_full = neg ? (~mag_ext + bpsd_pkg::ValW'(1)) : mag_ext;

    num_o.done     = step_i && !cont;
    num_o.is_zero  = (mag == '0);
    num_o.add_mark = neg && (mag == (bpsd_pkg::LitW-1)'(bpsd_pkg::MarkAddMag));
    num_o.del_mark = !neg && (mag == (bpsd_pkg::LitW-1)'(bpsd_pkg::MarkDelMag));
    num_o.value    = val_full[bpsd_pkg::TokW-1:0];
  end

endmodule

/* sv/bpsd_parser.sv */
module bpsd_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpsd_pkg::num_t                num_i,
  input  logic [bpsd_pkg::ModeW-1:0]    mode_i,
  output logic                          ended_o,
  output logic                          emit_o,
  output logic [bpsd_pkg::KindW-1:0]    kind_o,
  output logic [bpsd_pkg::TokW-1:0]     value_o
);

  typedef enum logic [2:0] {
    PH_MARKER,
    PH_ADD_ID,
    PH_ADD_ITEMS,
    PH_DEL_ITEMS,
    PH_ENDED
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [bpsd_pkg::ZeroCntW-1:0]   zeros_q, zeros_d, zeros_inc;
  logic [bpsd_pkg::TokW-1:0]       last_id_q, last_id_d;
  logic [bpsd_pkg::ModeW-1:0]      mode_eff;

  // Zero acts as one and three acts as two
  assign mode_eff  = {mode_i[1], ~mode_i[1]};
  assign zeros_inc = zeros_q + bpsd_pkg::ZeroCntW'(1);
  assign ended_o   = (phase_q == PH_ENDED);

  // Decode one finished number against the line phase
  always_comb begin
    phase_d   = phase_q;
    zeros_d   = zeros_q;
    last_id_d = last_id_q;
    emit_o    = 1'b0;
    kind_o    = bpsd_pkg::KIND_ITEM;
    value_o   = '0;
    if (num_i.done) begin
      case (phase_q)
        PH_MARKER: begin
          if (num_i.add_mark) begin
            phase_d = PH_ADD_ID;
          end else if (num_i.del_mark) begin
            phase_d = PH_DEL_ITEMS;
            emit_o  = 1'b1;
            kind_o  = bpsd_pkg::KIND_DEL_START;
            value_o = last_id_q;
          end else begin
            phase_d = PH_ENDED;
            emit_o  = 1'b1;
            kind_o  = bpsd_pkg::KIND_STREAM_END;
          end
        end
        PH_ADD_ID: begin
          last_id_d = num_i.value;
          zeros_d   = '0;
          phase_d   = PH_ADD_ITEMS;
          emit_o    = 1'b1;
          kind_o    = bpsd_pkg::KIND_ADD_ID;
          value_o   = num_i.value;
        end
        PH_ADD_ITEMS: begin
          emit_o = 1'b1;
          if (num_i.is_zero) begin
            if (zeros_inc >= mode_eff) begin
              zeros_d = '0;
              phase_d = PH_MARKER;
              kind_o  = bpsd_pkg::KIND_LINE_END;
            end else begin
              zeros_d = zeros_inc;
            end
          end else begin
            value_o = num_i.value;
          end
        end
        PH_DEL_ITEMS: begin
          emit_o = 1'b1;
          if (num_i.is_zero) begin
            phase_d = PH_MARKER;
            kind_o  = bpsd_pkg::KIND_LINE_END;
          end else begin
            value_o = num_i.value;
          end
        end
        default: begin
          phase_d = PH_ENDED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MARKER;
      zeros_q   <= '0;
      last_id_q <= '0;
    end else begin
      phase_q   <= phase_d;
      zeros_q   <= zeros_d;
      last_id_q <= last_id_d;
    end
  end

  // A line end only ever comes from a zero value
  a_line_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_o && kind_o == bpsd_pkg::KIND_LINE_END) |-> num_i.is_zero)
    else $error("line end without a zero value");

  // The addition id is kept for the next deletion line
  a_id_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (num_i.done && phase_q == PH_ADD_ID) |=> (last_id_q == $past(num_i.value)))
    else $error("addition id not kept");

  // The end of the stream holds until reset
  a_end_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_ENDED) |=> (phase_q == PH_ENDED && !emit_o))
    else $error("decoder left the stream end");

endmodule

/* sv/binary_proof_stream_decoder.sv */
// Binary proof stream decoder.
// Input channel: byte_valid_i / byte_stall_o / byte_in_i carry one raw byte of
// the compressed proof per item. Output channel: token_valid_o / token_stall_i
// carry one token (token_kind_o, token_value_o). An item moves at an edge with
// valid high and stall low. The configuration channel (cfg_valid_i,
// cfg_ready_o, zero_terminators_i) sets the zero count that closes an addition
// line; the user writes it only while the decoder is idle, and the decoder
// itself does not enforce this. A byte that closes a number passes through the
// input register and then the token register before its token is offered;
// continued bytes and the addition marker yield no token.
// Throughput: one byte per cycle while the receiver does not stall; the number
// decode and the line parser both fit between the input register and the
// token register. Reset clears the accumulator, the line phase, the kept line
// id and both registers, and sets the zero count to one.
// When the receiver stalls, the token register holds; one more byte waits in
// the input register, and then byte_stall_o rises until the token is taken.
// After the stream end token, further bytes are accepted and dropped.
module binary_proof_stream_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              byte_valid_i,
  output logic                              byte_stall_o,
  input  logic [bpsd_pkg::ByteW-1:0]        byte_in_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bpsd_pkg::ModeW-1:0]        zero_terminators_i,
  output logic                              token_valid_o,
  input  logic                              token_stall_i,
  output logic [bpsd_pkg::KindW-1:0]        token_kind_o,
  output logic signed [bpsd_pkg::TokW-1:0]  token_value_o
);

  logic                           in_valid_q;
  logic [bpsd_pkg::ByteW-1:0]     in_byte_q;
  logic [bpsd_pkg::ModeW-1:0]     mode_q;
  logic                           out_valid_q;
  logic [bpsd_pkg::KindW-1:0]     kind_q;
  logic [bpsd_pkg::TokW-1:0]      value_q;
  logic                           out_free, fire, step, in_accept;
  logic                           ended, emit;
  logic [bpsd_pkg::KindW-1:0]     emit_kind;
  logic [bpsd_pkg::TokW-1:0]      emit_value;
  bpsd_pkg::num_t                 num;

  // Handshake control
  assign out_free     = !out_valid_q || !token_stall_i;
  assign fire         = in_valid_q && out_free;
  assign step         = fire && !ended;
  assign byte_stall_o = in_valid_q && !out_free;
  assign in_accept    = byte_valid_i && !byte_stall_o;
  assign cfg_ready_o  = 1'b1;

  // Hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bpsd_pkg::ModeW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= zero_terminators_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= byte_in_i;
    end
  end

  bpsd_varint u_varint (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .num_o  (num)
  );

  bpsd_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .num_i   (num),
    .mode_i  (mode_q),
    .ended_o (ended),
    .emit_o  (emit),
    .kind_o  (emit_kind),
    .value_o (emit_value)
  );

  // Token register: load on a processed byte, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= emit;
    end else if (!token_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      kind_q  <= emit_kind;
      value_q <= emit_value;
    end
  end

  assign token_valid_o = out_valid_q;
  assign token_kind_o  = kind_q;
  assign token_value_o = value_q;

  // A waiting token is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && token_stall_i) |-> !fire)
    else $error("token register overwritten while stalled");

  // Nothing is decoded after the stream end
  a_no_step_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended |-> !num.done)
    else $error("number finished after stream end");

  // A delivered token carries a defined kind
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (kind_q <= bpsd_pkg::KIND_STREAM_END))
    else $error("token kind out of range");

endmodule

/* verif/bpsd_token_checker.sv */
`timescale 1ns / 100ps

module bpsd_token_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              byte_valid_i,
  input  logic                              byte_stall_i,
  input  logic [bpsd_pkg::ByteW-1:0]        byte_in_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [bpsd_pkg::ModeW-1:0]        zero_terminators_i,
  input  logic                              token_valid_i,
  input  logic                              token_stall_i,
  input  logic [bpsd_pkg::KindW-1:0]        token_kind_i,
  input  logic signed [bpsd_pkg::TokW-1:0]  token_value_i,
  output int unsigned                       tokens_due_o,
  output int unsigned                       fail_count_o
);

  typedef struct packed {
    logic [bpsd_pkg::KindW-1:0] kind;
    logic [bpsd_pkg::TokW-1:0]  value;
  } token_t;

  typedef enum logic [2:0] {
    AWAIT_MARK,
    AWAIT_ID,
    IN_CLAUSE,
    IN_DELETE,
    STREAM_DONE
  } line_phase_e;

  line_phase_e                   line_phase;
  logic [bpsd_pkg::LitW-1:0]     number_acc;
  logic [bpsd_pkg::ShiftW-1:0]   group_pos;
  logic [bpsd_pkg::ZeroCntW-1:0] zeros_seen;
  logic [bpsd_pkg::TokW-1:0]     kept_id;
  logic [bpsd_pkg::ModeW-1:0]    zero_mode;
  token_t                        tokens_due[$];
  int unsigned                   fails;

  // Fold one byte into the number; on the last byte, run the line parser
  task automatic decode_byte(input logic [bpsd_pkg::ByteW-1:0] b);
    logic [63:0]                   widened;
    logic [bpsd_pkg::LitW-1:0]     raw;
    logic [bpsd_pkg::LitW-1:0]     mag;
    logic [bpsd_pkg::TokW-1:0]     sval;
    logic                          neg;
    logic                          zero;
    logic [bpsd_pkg::ZeroCntW-1:0] need;
    token_t                        tok;
    logic                          emit;

    emit = 1'b0;
    tok  = '0;
    if (line_phase == STREAM_DONE) return;

    // Drop groups at or beyond the literal width, saturate the position
    if (int'(group_pos) < bpsd_pkg::LitW) begin
      widened    = 64'(b[bpsd_pkg::GroupBits-1:0]) << group_pos;
      number_acc = number_acc | widened[bpsd_pkg::LitW-1:0];
    end
    if (int'(group_pos) > bpsd_pkg::ShiftMax - bpsd_pkg::GroupBits)
      group_pos = bpsd_pkg::ShiftW'(bpsd_pkg::ShiftMax);
    else group_pos = group_pos + bpsd_pkg::ShiftW'(bpsd_pkg::GroupBits);
    if (b[bpsd_pkg::ByteW-1]) return;

    raw        = number_acc;
    number_acc = '0;
    group_pos  = '0;
    mag        = raw >> 1;
    neg        = raw[0];
    sval       = neg ? bpsd_pkg::TokW'(-mag) : bpsd_pkg::TokW'(mag);
    zero       = (mag == '0);
    // Out-of-range modes fold to the nearest legal one
    if (zero_mode == 2'd0) need = 2'd1;
    else if (zero_mode == 2'd3) need = 2'd2;
    else need = zero_mode;

    case (line_phase)
      AWAIT_MARK: begin
        if (neg && mag == bpsd_pkg::LitW'(bpsd_pkg::MarkAddMag)) begin
          line_phase = AWAIT_ID;
        end else if (!neg && mag == bpsd_pkg::LitW'(bpsd_pkg::MarkDelMag)) begin
          line_phase = IN_DELETE;
          tok  = '{kind: bpsd_pkg::KIND_DEL_START, value: kept_id};
          emit = 1'b1;
        end else begin
          line_phase = STREAM_DONE;
          tok  = '{kind: bpsd_pkg::KIND_STREAM_END, value: '0};
          emit = 1'b1;
        end
      end
      AWAIT_ID: begin
        kept_id    = sval;
        zeros_seen = '0;
        line_phase = IN_CLAUSE;
        tok  = '{kind: bpsd_pkg::KIND_ADD_ID, value: sval};
        emit = 1'b1;
      end
      IN_CLAUSE: begin
        emit = 1'b1;
        tok  = '{kind: bpsd_pkg::KIND_ITEM, value: sval};
        if (zero) begin
          zeros_seen = zeros_seen + 1'b1;
          if (zeros_seen >= need) begin
            zeros_seen = '0;
            line_phase = AWAIT_MARK;
            tok = '{kind: bpsd_pkg::KIND_LINE_END, value: '0};
          end else begin
            tok = '{kind: bpsd_pkg::KIND_ITEM, value: '0};
          end
        end
      end
      IN_DELETE: begin
        emit = 1'b1;
        tok  = '{kind: bpsd_pkg::KIND_ITEM, value: sval};
        if (zero) begin
          line_phase = AWAIT_MARK;
          tok = '{kind: bpsd_pkg::KIND_LINE_END, value: '0};
        end
      end
      default: line_phase = STREAM_DONE;
    endcase
    if (emit) tokens_due.push_back(tok);
  endtask

  // Check taken tokens, track the mode, predict from taken bytes
  always @(posedge clk_i or negedge rst_ni) begin
    token_t want;
    if (!rst_ni) begin
      line_phase = AWAIT_MARK;
      number_acc = '0;
      group_pos  = '0;
      zeros_seen = '0;
      kept_id    = '0;
      zero_mode  = 2'd1;
      fails      = 0;
      tokens_due.delete();
      tokens_due_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (token_valid_i && !token_stall_i) begin
        if (tokens_due.size() == 0) begin
          $display("%0t: unexpected token: expected none, got kind %0d value %0d",
                   $time, token_kind_i, token_value_i);
          fails++;
        end else begin
          want = tokens_due.pop_front();
          if (token_kind_i !== want.kind) begin
            $display("%0t: token kind mismatch: expected %0d, got %0d",
                     $time, want.kind, token_kind_i);
            fails++;
          end
          if (token_value_i !== want.value) begin
            $display("%0t: token value mismatch (kind %0d): expected %0d, got %0d",
                     $time, want.kind, $signed(want.value), token_value_i);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) zero_mode = zero_terminators_i;
      if (byte_valid_i && !byte_stall_i) decode_byte(byte_in_i);
      tokens_due_o <= tokens_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

/* verif/binary_proof_stream_decoder_tb.sv */
`timescale 1ns / 100ps

module binary_proof_stream_decoder_tb;

  localparam int          RandomBytes  = 900;
  localparam int          PhaseCount   = 7;
  localparam int          DrainCycles  = 4;
  localparam int          WatchdogMax  = 400;
  localparam logic [31:0] AddMarkRaw   = 32'(2 * bpsd_pkg::MarkAddMag + 1);
  localparam logic [31:0] DelMarkRaw   = 32'(2 * bpsd_pkg::MarkDelMag);

  logic                             clk_i              = 1'b0;
  logic                             rst_ni             = 1'b0;
  logic                             byte_valid_i       = 1'b0;
  logic                             byte_stall_o;
  logic [bpsd_pkg::ByteW-1:0]       byte_in_i          = '0;
  logic                             cfg_valid_i        = 1'b0;
  logic                             cfg_ready_o;
  logic [bpsd_pkg::ModeW-1:0]       zero_terminators_i = '0;
  logic                             token_valid_o;
  logic                             token_stall_i      = 1'b0;
  logic [bpsd_pkg::KindW-1:0]       token_kind_o;
  logic signed [bpsd_pkg::TokW-1:0] token_value_o;

  int unsigned tokens_due;
  int unsigned fail_count;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          stall_on = 1'b0;
  bit          sender_gaps = 1'b0;
  int          line_mode = 1;

  // Fixed opening: deletion before any addition, extreme ids and items,
  // dropped high groups, deletion carrying the kept id
  logic [bpsd_pkg::ByteW-1:0] opening_bytes [23] = '{
    8'h64, 8'h00,
    8'h61, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
    8'h80, 8'h80, 8'h80, 8'h80, 8'hFF, 8'h7F,
    8'h00,
    8'h64, 8'h03, 8'h00
  };

  logic [bpsd_pkg::ModeW-1:0] mode_plan [PhaseCount] =
    '{2'd1, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd3};

  always #6 clk_i = ~clk_i;

  binary_proof_stream_decoder dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .byte_valid_i       (byte_valid_i),
    .byte_stall_o       (byte_stall_o),
    .byte_in_i          (byte_in_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .zero_terminators_i (zero_terminators_i),
    .token_valid_o      (token_valid_o),
    .token_stall_i      (token_stall_i),
    .token_kind_o       (token_kind_o),
    .token_value_o      (token_value_o)
  );

  bpsd_token_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .byte_valid_i       (byte_valid_i),
    .byte_stall_i       (byte_stall_o),
    .byte_in_i          (byte_in_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .zero_terminators_i (zero_terminators_i),
    .token_valid_i      (token_valid_o),
    .token_stall_i      (token_stall_i),
    .token_kind_i       (token_kind_o),
    .token_value_i      (token_value_o),
    .tokens_due_o       (tokens_due),
    .fail_count_o       (fail_count)
  );

  // Stall the token side in random bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_stall_i <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      token_stall_i <= 1'b1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 9);
      token_stall_i <= 1'b1;
    end else begin
      token_stall_i <= 1'b0;
    end
  end

  // Abort when no channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_valid_i && !byte_stall_o) || (token_valid_o && !token_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogMax) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one byte, with an occasional gap first, and hold until taken
  task automatic send_byte(input logic [bpsd_pkg::ByteW-1:0] b);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      byte_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    byte_valid_i <= 1'b1;
    byte_in_i    <= b;
    @(posedge clk_i);
    while (byte_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Encode a raw number as 7-bit groups, plus overlong groups with junk
  // in the bits that the decoder drops
  task automatic send_number(input logic [31:0] raw, input int pad);
    logic [63:0] wide;
    logic [6:0]  grp;
    int          groups;
    int          total;

    wide   = {32'b0, raw};
    groups = 1;
    while (groups < 5 && (wide >> (7 * groups)) != 0) groups++;
    total = groups + pad;
    for (int i = 0; i < total; i++) begin
      if (i < 4) grp = wide[7 * i +: 7];
      else if (i == 4) grp = {3'($urandom), raw[31:28]};
      else grp = 7'($urandom);
      send_byte({(i < total - 1), grp});
    end
  endtask

  function automatic int pick_pad();
    int r;
    r = $urandom_range(0, 15);
    if (r < 12) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(4, 10);
  endfunction

  // Raw literal whose decoded value is never zero
  function automatic logic [31:0] nonzero_literal();
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    if (v[31:1] == '0) v[1] = 1'b1;
    return v;
  endfunction

  task automatic send_zero();
    send_number(32'($urandom_range(0, 1)), pick_pad());
  endtask

  // One addition or deletion line; a few carry marker values as items
  task automatic send_line();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_number(AddMarkRaw, pick_pad());
      send_number($urandom >> $urandom_range(0, 31), pick_pad());
      repeat ($urandom_range(0, 6)) send_number(nonzero_literal(), pick_pad());
      if (r < 8) send_number($urandom_range(0, 1) ? AddMarkRaw : DelMarkRaw, pick_pad());
      if (line_mode == 2) begin
        send_zero();
        repeat ($urandom_range(0, 4)) send_number(nonzero_literal(), pick_pad());
      end
      send_zero();
    end else begin
      send_number(DelMarkRaw, pick_pad());
      repeat ($urandom_range(0, 5)) send_number(nonzero_literal(), pick_pad());
      if (r > 92) send_number($urandom_range(0, 1) ? AddMarkRaw : DelMarkRaw, pick_pad());
      send_zero();
    end
  endtask

  // Hold the sender until every token has come and the pipe is empty
  task automatic wait_drained();
    byte_valid_i <= 1'b0;
    @(negedge clk_i);
    while (tokens_due != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [bpsd_pkg::ModeW-1:0] mode);
    wait_drained();
    cfg_valid_i        <= 1'b1;
    zero_terminators_i <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (mode == 2'd0) line_mode = 1;
    else if (mode == 2'd3) line_mode = 2;
    else line_mode = int'(mode);
  endtask

  initial begin
    int unsigned phase_start;
    logic [31:0] end_raw;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    // Random lines, one mode per phase; the last phase runs without gaps
    for (int p = 0; p < PhaseCount; p++) begin
      if (p != 0) write_mode(mode_plan[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RandomBytes / PhaseCount) begin
        sender_gaps = (p < PhaseCount - 1) && ($urandom_range(0, 4) != 0);
        stall_on   <= (p < PhaseCount - 1) && ($urandom_range(0, 4) != 0);
        if ((p < PhaseCount - 1) && $urandom_range(0, 24) == 0) wait_drained();
        send_line();
      end
    end

    // Close the stream with a non-marker value, then feed ignored bytes
    end_raw = $urandom_range(0, 200);
    if (end_raw == AddMarkRaw || end_raw == DelMarkRaw) end_raw = 32'd96;
    send_number(end_raw, pick_pad());
    repeat (12) send_byte(8'($urandom));

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && tokens_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
